### rtl/aliq_pkg.sv
// Shared widths, result class codes and controller/datapath command types.
package aliq_pkg;

   localparam int ValueWidthDefault = 16;
   localparam int FieldWidth = 16;
   localparam int SumOutWidth = 18;
   localparam int ClassWidth = 2;

   typedef enum logic [ClassWidth-1:0] {
      CLASS_DEFICIENT = 2'd0,
      CLASS_PERFECT   = 2'd1,
      CLASS_ABUNDANT  = 2'd2
   } number_class_type;

   typedef struct packed {
      logic load;         // capture both input values
      logic init_walk;    // start a divisor walk over the selected value
      logic select_b;     // walk the second value instead of the first
      logic div_start;    // launch a divisibility test of the current candidate
      logic accumulate;   // fold the test result into the sum and advance
      logic store_sum;    // keep the finished sum for the selected value
      logic publish;      // load the result register
   } aliq_cmd_type;

   typedef struct packed {
      logic walk_done;    // candidate squared exceeds the value
      logic div_done;     // divider has a valid quotient and remainder
   } aliq_status_type;

endpackage

### rtl/aliq_req_if.sv
// Request channel interface carrying the two values of one transaction.
interface aliq_req_if;
   import aliq_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [FieldWidth-1:0] first_value;
   logic [FieldWidth-1:0] second_value;

   modport source (output valid, output first_value, output second_value, input ready);
   modport sink (input valid, input first_value, input second_value, output ready);
endinterface

### rtl/aliq_rsp_if.sv
// Response channel interface carrying the sum, class and pair flag of one transaction.
interface aliq_rsp_if;
   import aliq_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SumOutWidth-1:0] aliquot_sum;
   logic [ClassWidth-1:0]  number_class;
   logic                   amicable_pair;

   modport source (output valid, output aliquot_sum, output number_class,
                   output amicable_pair, input ready);
   modport sink (input valid, input aliquot_sum, input number_class,
                 input amicable_pair, output ready);
endinterface

### rtl/aliq_divider.sv
// Iterative restoring divider producing one quotient bit per cycle.
module aliq_divider #(
   parameter int VALUE_WIDTH = aliq_pkg::ValueWidthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] numerator,
   input  logic [VALUE_WIDTH-1:0] divisor,
   output logic [VALUE_WIDTH-1:0] quotient,
   output logic [VALUE_WIDTH-1:0] remainder,
   output logic                   done
);
   import aliq_pkg::*;

   localparam int CountWidth = $clog2(VALUE_WIDTH + 1);

   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [VALUE_WIDTH:0]   rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [VALUE_WIDTH-1:0] dvs_ff, dvs_in;
   logic [VALUE_WIDTH:0]   rem_shift;
   logic [VALUE_WIDTH:0]   rem_diff;

   always_comb begin
      rem_shift = {rem_ff[VALUE_WIDTH-1:0], quo_ff[VALUE_WIDTH-1]};
      rem_diff  = rem_shift - {1'b0, dvs_ff};
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = done_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      if (start) begin
         rem_in   = '0;
         quo_in   = numerator;
         dvs_in   = divisor;
         count_in = CountWidth'(VALUE_WIDTH);
         busy_in  = 1'b1;
         done_in  = 1'b0;
      end else if (busy_ff) begin
         // Restoring step: keep the difference only when it does not go negative.
         if (rem_shift >= {1'b0, dvs_ff}) begin
            rem_in = rem_diff;
            quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CountWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff[VALUE_WIDTH-1:0];
   assign done      = done_ff;

endmodule

### rtl/aliq_datapath.sv
// Datapath: operand and sum registers, divisor walk, divider and result register.
module aliq_datapath #(
   parameter int VALUE_WIDTH = aliq_pkg::ValueWidthDefault
) (
   input  logic                              clock,
   input  aliq_pkg::aliq_cmd_type            cmd,
   output aliq_pkg::aliq_status_type         status,
   input  logic [aliq_pkg::FieldWidth-1:0]   first_value,
   input  logic [aliq_pkg::FieldWidth-1:0]   second_value,
   output logic [aliq_pkg::SumOutWidth-1:0]  aliquot_sum,
   output logic [aliq_pkg::ClassWidth-1:0]   number_class,
   output logic                              amicable_pair
);
   import aliq_pkg::*;

   // The sum of proper divisors stays below eight times the value.
   localparam int SumWidth = VALUE_WIDTH + 3;
   localparam int SqWidth  = VALUE_WIDTH + 2;

   logic [VALUE_WIDTH-1:0] a_ff, a_in;
   logic [VALUE_WIDTH-1:0] b_ff, b_in;
   logic [VALUE_WIDTH-1:0] n_ff, n_in;
   logic [VALUE_WIDTH-1:0] i_ff, i_in;
   logic [SqWidth-1:0]     sq_ff, sq_in;
   logic [SumWidth-1:0]    sum_ff, sum_in;
   logic [SumWidth-1:0]    sa_ff, sa_in;
   logic [SumWidth-1:0]    sb_ff, sb_in;
   logic [SumOutWidth-1:0] out_sum_ff, out_sum_in;
   number_class_type       out_class_ff, out_class_in;
   logic                   out_ami_ff, out_ami_in;

   logic [VALUE_WIDTH-1:0] div_quo;
   logic [VALUE_WIDTH-1:0] div_rem;
   logic                   div_done;
   logic                   divides;
   logic                   add_i;
   logic                   add_q;
   logic [SumWidth-1:0]    a_ext;
   logic [SumWidth-1:0]    b_ext;

   aliq_divider #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (1'b0),
      .start     (cmd.div_start),
      .numerator (n_ff),
      .divisor   (i_ff),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   always_comb begin
      divides = (div_rem == '0);
      add_i   = divides && (i_ff != n_ff);
      add_q   = divides && (div_quo != n_ff) && (div_quo != i_ff);
      a_ext   = SumWidth'(a_ff);
      b_ext   = SumWidth'(b_ff);

      a_in       = a_ff;
      b_in       = b_ff;
      n_in       = n_ff;
      i_in       = i_ff;
      sq_in      = sq_ff;
      sum_in     = sum_ff;
      sa_in      = sa_ff;
      sb_in      = sb_ff;
      out_sum_in = out_sum_ff;
      out_class_in = out_class_ff;
      out_ami_in = out_ami_ff;

      if (cmd.load) begin
         a_in = VALUE_WIDTH'(first_value);
         b_in = VALUE_WIDTH'(second_value);
      end
      if (cmd.init_walk) begin
         n_in   = cmd.select_b ? b_ff : a_ff;
         i_in   = VALUE_WIDTH'(1);
         sq_in  = SqWidth'(1);
         sum_in = '0;
      end
      if (cmd.accumulate) begin
         // Pairs (i, n/i) are collected together; the value itself is excluded.
         sum_in = sum_ff + (add_i ? SumWidth'(i_ff) : '0)
                         + (add_q ? SumWidth'(div_quo) : '0);
         // (i+1)^2 = i^2 + 2i + 1
         sq_in  = sq_ff + {1'b0, i_ff, 1'b1};
         i_in   = i_ff + 1'b1;
      end
      if (cmd.store_sum) begin
         if (cmd.select_b) begin
            sb_in = sum_ff;
         end else begin
            sa_in = sum_ff;
         end
      end
      if (cmd.publish) begin
         out_sum_in = SumOutWidth'(sa_ff);
         if (a_ff == '0 || sa_ff < a_ext) begin
            out_class_in = CLASS_DEFICIENT;
         end else if (sa_ff == a_ext) begin
            out_class_in = CLASS_PERFECT;
         end else begin
            out_class_in = CLASS_ABUNDANT;
         end
         out_ami_in = (a_ff != '0) && (b_ff != '0) && (sa_ff == b_ext) && (sb_ff == a_ext);
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      n_ff         <= n_in;
      i_ff         <= i_in;
      sq_ff        <= sq_in;
      sum_ff       <= sum_in;
      sa_ff        <= sa_in;
      sb_ff        <= sb_in;
      out_sum_ff   <= out_sum_in;
      out_class_ff <= out_class_in;
      out_ami_ff   <= out_ami_in;
   end

   assign status.walk_done = (sq_ff > SqWidth'(n_ff));
   assign status.div_done  = div_done;
   assign aliquot_sum      = out_sum_ff;
   assign number_class     = out_class_ff;
   assign amicable_pair    = out_ami_ff;

endmodule

### rtl/aliq_ctrl.sv
// Controller state machine sequencing the two divisor walks and the result handoff.
module aliq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output aliq_pkg::aliq_cmd_type    cmd,
   input  aliq_pkg::aliq_status_type status
);
   import aliq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_CHECK,
      ST_DIVIDE,
      ST_ACCUM,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      select_b_ff, select_b_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      slot_free;

   always_comb begin
      accept       = req_valid && (state_ff == ST_IDLE);
      slot_free    = !rsp_valid_ff || rsp_ready;
      state_in     = state_ff;
      select_b_in  = select_b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.select_b = select_b_ff;
      cmd.load     = accept;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               select_b_in = 1'b0;
               state_in    = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init_walk = 1'b1;
            state_in      = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.walk_done) begin
               cmd.store_sum = 1'b1;
               if (select_b_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  select_b_in = 1'b1;
                  state_in    = ST_INIT;
               end
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            cmd.accumulate = 1'b1;
            state_in       = ST_CHECK;
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         select_b_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         select_b_ff  <= select_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/aliquot_sum_number_classifier.sv
// Each divisor candidate passes through a check state, a divide state that waits for the
// bit-serial divider, and an accumulate state; the divider dominates the worst case.
// One transaction is in flight at a time and the next can be taken in the cycle after
// publication; a finished result waits in the output register meanwhile. Synchronous
// active-high reset clears control only.
module aliquot_sum_number_classifier #(
   parameter int VALUE_WIDTH = aliq_pkg::ValueWidthDefault
) (
   input logic       clock,
   input logic       reset,
   aliq_req_if.sink  req_chan,
   aliq_rsp_if.source rsp_chan
);
   import aliq_pkg::*;

   // Commands flow from the controller into the datapath, status flows back.
   aliq_cmd_type    cmd;
   aliq_status_type status;

   // The controller decides when transactions are taken and when a result is shown.
   aliq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath walks candidates up to the square root of each value, adding the members
   // of every divisor pair but the value itself, then classifies the first value and tests the pair.
   aliq_datapath #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .status        (status),
      .first_value   (req_chan.first_value),
      .second_value  (req_chan.second_value),
      .aliquot_sum   (rsp_chan.aliquot_sum),
      .number_class  (rsp_chan.number_class),
      .amicable_pair (rsp_chan.amicable_pair)
   );

endmodule

### dv/aliquot_sum_number_classifier_tb.sv
// Testbench for the aliquot-sum number classifier: a self-checking predictor with random stalls.

// Holds the predicted results in order of acceptance and compares them with the block's output.
class aliquot_scoreboard;

   typedef struct packed {
      logic [aliq_pkg::SumOutWidth-1:0] sum;
      aliq_pkg::number_class_type       cls;
      logic                             pair;
   } classification_type;

   classification_type expected_q[$];
   int mismatches;

   function new();
      mismatches = 0;
   endfunction

   // Sum of proper divisors, walked in divisor pairs up to the square root.
   static function longint unsigned proper_divisor_sum(longint unsigned n);
      longint unsigned total;
      longint unsigned d;
      longint unsigned q;
      total = 0;
      if (n < 2) begin
         return 0;
      end
      for (d = 1; d * d <= n; d++) begin
         if (n % d == 0) begin
            q = n / d;
            if (d != n) begin
               total += d;
            end
            if (q != n && q != d) begin
               total += q;
            end
         end
      end
      return total;
   endfunction

   function void note_request(logic [aliq_pkg::FieldWidth-1:0] first_value,
                              logic [aliq_pkg::FieldWidth-1:0] second_value);
      classification_type res;
      longint unsigned first_sum;
      longint unsigned second_sum;
      first_sum  = proper_divisor_sum(first_value);
      second_sum = proper_divisor_sum(second_value);
      res.sum = first_sum[aliq_pkg::SumOutWidth-1:0];
      if (first_value == 0 || first_sum < first_value) begin
         res.cls = aliq_pkg::CLASS_DEFICIENT;
      end else if (first_sum == first_value) begin
         res.cls = aliq_pkg::CLASS_PERFECT;
      end else begin
         res.cls = aliq_pkg::CLASS_ABUNDANT;
      end
      res.pair = (first_value != 0) && (second_value != 0) &&
                 (first_sum == second_value) && (second_sum == first_value);
      expected_q.push_back(res);
   endfunction

   function void check_response(logic [aliq_pkg::SumOutWidth-1:0] sum,
                                logic [aliq_pkg::ClassWidth-1:0]  cls,
                                logic                             pair);
      classification_type exp;
      if (expected_q.size() == 0) begin
         $error("unexpected transaction: aliquot_sum %0d number_class %0d amicable_pair %0d",
                sum, cls, pair);
         mismatches++;
         return;
      end
      exp = expected_q.pop_front();
      if (sum !== exp.sum) begin
         $error("aliquot_sum: expected %0d, actual %0d", exp.sum, sum);
         mismatches++;
      end
      if (cls !== exp.cls) begin
         $error("number_class: expected %0d, actual %0d", exp.cls, cls);
         mismatches++;
      end
      if (pair !== exp.pair) begin
         $error("amicable_pair: expected %0d, actual %0d", exp.pair, pair);
         mismatches++;
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

endclass

module aliquot_sum_number_classifier_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import aliq_pkg::*;

   localparam int RandomPairs = 80;

   // Kinds of random transaction. Most of them are built to hit the perfect and amicable
   // paths, since purely random pairs almost never reach them.
   typedef enum int {
      PICK_AMICABLE,
      PICK_PERFECT,
      PICK_NEAR_MISS,
      PICK_SUM_CHAIN,
      PICK_NARROW,
      PICK_FULL
   } pair_kind_type;

   logic clock;
   logic reset;

   aliq_req_if req_chan ();
   aliq_rsp_if rsp_chan ();

   aliquot_sum_number_classifier dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   aliquot_scoreboard classifier_sb = new();

   // Every amicable pair whose members both fit in 16 bits, and the perfect numbers below 2^16.
   logic [FieldWidth-1:0] amicable_lo [8] = '{220, 1184, 2620, 5020, 6232, 10744, 12285, 17296};
   logic [FieldWidth-1:0] amicable_hi [8] = '{284, 1210, 2924, 5564, 6368, 10856, 14595, 18416};
   logic [FieldWidth-1:0] perfect_numbers [4] = '{6, 28, 496, 8128};

   // Directed corner cases: zeros, ones, field extremes, all three classes, perfect numbers
   // paired with themselves, amicable pairs in both orders, and sums above 16 bits.
   logic [FieldWidth-1:0] corner_first [22] = '{
      0, 1, 0, 1, 0, 65535, 65535, 2, 12, 6, 28,
      496, 8128, 220, 284, 220, 6, 55440, 65521, 32768, 45360, 0
   };
   logic [FieldWidth-1:0] corner_second [22] = '{
      0, 1, 1, 0, 65535, 0, 65535, 3, 12, 6, 28,
      496, 8128, 284, 220, 285, 28, 1, 65521, 16384, 8, 6
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one, and often none at all.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 60);
   endfunction

   // Presents one transaction after an optional idle gap and returns at the edge where it is
   // taken. Valid stays high on return, so a back-to-back caller simply overwrites the payload
   // in the same time step; anyone who wants to stop must lower valid first.
   task automatic send_pair(input logic [FieldWidth-1:0] first_value,
                            input logic [FieldWidth-1:0] second_value,
                            input int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.first_value  <= first_value;
      req_chan.second_value <= second_value;
      do @(posedge clock); while (!req_chan.ready);
      classifier_sb.note_request(first_value, second_value);
   endtask

   task automatic wait_until_drained();
      while (classifier_sb.pending() != 0) @(posedge clock);
   endtask

   // Builds one random pair. Large operands make the divider walk long, so full-width values
   // are kept to a minority and the narrow kind shrinks its values by a random shift.
   task automatic pick_pair(output logic [FieldWidth-1:0] first_value,
                            output logic [FieldWidth-1:0] second_value);
      pair_kind_type kind;
      int roll;
      int idx;
      logic [FieldWidth-1:0] tmp;
      longint unsigned chained;
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
         kind = PICK_AMICABLE;
      end else if (roll < 32) begin
         kind = PICK_PERFECT;
      end else if (roll < 42) begin
         kind = PICK_NEAR_MISS;
      end else if (roll < 55) begin
         kind = PICK_SUM_CHAIN;
      end else if (roll < 85) begin
         kind = PICK_NARROW;
      end else begin
         kind = PICK_FULL;
      end
      case (kind)
         PICK_AMICABLE: begin
            idx = $urandom_range(0, 7);
            first_value  = amicable_lo[idx];
            second_value = amicable_hi[idx];
         end
         PICK_PERFECT: begin
            idx = $urandom_range(0, 3);
            first_value  = perfect_numbers[idx];
            // Usually paired with itself; sometimes with a neighbor so the flag must clear.
            second_value = ($urandom_range(0, 3) == 0) ? perfect_numbers[idx] + 1'b1
                                                       : perfect_numbers[idx];
         end
         PICK_NEAR_MISS: begin
            idx = $urandom_range(0, 7);
            first_value  = amicable_lo[idx];
            second_value = amicable_hi[idx];
            if ($urandom_range(0, 1) == 1) begin
               first_value = first_value + ($urandom_range(0, 1) ? 16'd1 : 16'hFFFF);
            end else begin
               second_value = second_value + ($urandom_range(0, 1) ? 16'd1 : 16'hFFFF);
            end
         end
         PICK_SUM_CHAIN: begin
            // The second value is the aliquot sum of the first, so half the pair test holds.
            first_value = 16'($urandom_range(2, 20000));
            chained = classifier_sb.proper_divisor_sum(first_value);
            second_value = (chained > 65535) ? 16'hFFFF : chained[FieldWidth-1:0];
         end
         PICK_NARROW: begin
            first_value  = 16'($urandom_range(0, 65535) >> $urandom_range(2, 15));
            second_value = 16'($urandom_range(0, 65535) >> $urandom_range(2, 15));
         end
         default: begin
            first_value  = 16'($urandom_range(0, 65535));
            second_value = 16'($urandom_range(0, 65535));
         end
      endcase
      if ($urandom_range(0, 1) == 1) begin
         tmp          = first_value;
         first_value  = second_value;
         second_value = tmp;
      end
   endtask

   // Stimulus: reset, the directed corners, then the random transactions with one full drain
   // in the middle so the sender also sees a completely idle block.
   initial begin
      logic [FieldWidth-1:0] first_value;
      logic [FieldWidth-1:0] second_value;
      int burst;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.first_value  <= '0;
      req_chan.second_value <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_first[i]) begin
         send_pair(corner_first[i], corner_second[i], pick_gap());
      end

      burst = 0;
      for (int n = 0; n < RandomPairs; n++) begin
         if (n == RandomPairs / 2) begin
            req_chan.valid <= 1'b0;
            wait_until_drained();
         end
         pick_pair(first_value, second_value);
         // Now and then run a stretch of transactions with no gaps at all.
         if (burst == 0 && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(3, 8);
         end
         if (burst > 0) begin
            burst--;
            send_pair(first_value, second_value, 0);
         end else begin
            send_pair(first_value, second_value, pick_gap());
         end
      end
      req_chan.valid <= 1'b0;

      // The output register is the last stage, so a short settling window is plenty.
      wait_until_drained();
      repeat (50) @(posedge clock);
      if (classifier_sb.mismatches == 0 && classifier_sb.pending() == 0) begin
         $display("aliquot_sum_number_classifier_tb passed");
      end else begin
         $display("aliquot_sum_number_classifier_tb failed");
      end
      $finish;
   end

   // Receiver backpressure: ready stays high for a random stretch, then drops for a gap.
   initial begin
      int stall;
      forever begin
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Every result transaction is checked against the oldest prediction at the edge it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         classifier_sb.check_response(rsp_chan.aliquot_sum, rsp_chan.number_class,
                                      rsp_chan.amicable_pair);
      end
   end

   // A transaction with large values takes long, so the bound is set from that worst case
   // across every transaction plus the longest stalls, and then taken several times over.
   initial begin
      #100ms;
      $display("aliquot_sum_number_classifier_tb failed");
      $finish;
   end

endmodule
